/* hdl/encoder_delta_speed_core_macros.svh */
// Assertion helpers for the encoder speed block.
`ifndef ENCODER_DELTA_SPEED_CORE_MACROS_SVH
`define ENCODER_DELTA_SPEED_CORE_MACROS_SVH

// Condition implies consequence in the same cycle.
`define EDS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition implies consequence in the next cycle.
`define EDS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/eds_pkg.sv */
package eds_pkg;

    localparam int CNT_W   = 32;
    localparam int DELTA_W = 33;
    localparam int SPEED_W = 48;
    localparam int FB_W    = 16;
    localparam int NUM_W   = 57;   // |delta| (33b) * 60000*256 (24b)
    localparam int DEN_W   = 64;   // counts_per_rev * dt_ms
    localparam int CFG_IDX_W = 2;

    localparam logic [23:0] MS_PER_MIN_Q8 = 24'd15360000;

    localparam logic [CFG_IDX_W-1:0] CFG_AUTORELOAD     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNTS_PER_REV = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK_MS    = 2'd2;

    localparam logic [CNT_W-1:0] AUTORELOAD_RST     = 32'd65535;
    localparam logic [CNT_W-1:0] COUNTS_PER_REV_RST = 32'd1024;
    localparam logic [FB_W-1:0]  FALLBACK_MS_RST    = 16'd10;

    localparam logic signed [SPEED_W-1:0] SPEED_MAX = {1'b0, {(SPEED_W-1){1'b1}}};
    localparam logic signed [SPEED_W-1:0] SPEED_MIN = {1'b1, {(SPEED_W-1){1'b0}}};

    typedef struct packed {
        logic signed [DELTA_W-1:0] delta;
        logic [CNT_W-1:0]          dt;
        logic                      baseline;
    } item_t;

endpackage

/* hdl/eds_front.sv */
module eds_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [eds_pkg::CNT_W-1:0] counter_value,
    input  logic [eds_pkg::CNT_W-1:0] tick_ms,
    input  logic [eds_pkg::CNT_W-1:0] autoreload,
    input  logic [eds_pkg::FB_W-1:0]  fallback_ms,
    input  logic                      q_full,
    output logic                      q_wr,
    output eds_pkg::item_t            q_data
);
    import eds_pkg::*;

    logic [CNT_W-1:0] prev_count_reg, prev_count_next;
    logic [CNT_W-1:0] prev_tick_reg, prev_tick_next;
    logic             base_valid_reg, base_valid_next;

    logic signed [CNT_W+1:0] diff;
    logic signed [CNT_W+1:0] range;
    logic signed [CNT_W+1:0] half;
    logic signed [CNT_W+1:0] mag;
    logic signed [CNT_W+1:0] folded;
    logic [CNT_W-1:0]        dt_raw;

    assign full = q_full;
    assign q_wr = push && !q_full;

    always_comb
    begin
        diff   = $signed({2'b00, counter_value}) - $signed({2'b00, prev_count_reg});
        range  = $signed({2'b00, autoreload}) + 34'sd1;
        half   = range >>> 1;
        mag    = diff[CNT_W+1] ? -diff : diff;
        folded = diff;
        if (mag > half)
        begin
            folded = diff[CNT_W+1] ? diff + range : diff - range;
        end
        dt_raw = tick_ms - prev_tick_reg;

        q_data.baseline = !base_valid_reg;
        q_data.delta    = base_valid_reg ? folded[DELTA_W-1:0] : '0;
        q_data.dt       = (dt_raw == '0) ? {{(CNT_W-FB_W){1'b0}}, fallback_ms} : dt_raw;

        prev_count_next = prev_count_reg;
        prev_tick_next  = prev_tick_reg;
        base_valid_next = base_valid_reg;
        if (q_wr)
        begin
            prev_count_next = counter_value;
            prev_tick_next  = tick_ms;
            base_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_count_reg <= '0;
            prev_tick_reg  <= '0;
            base_valid_reg <= 1'b0;
        end
        else
        begin
            prev_count_reg <= prev_count_next;
            prev_tick_reg  <= prev_tick_next;
            base_valid_reg <= base_valid_next;
        end
    end

endmodule

/* hdl/eds_queue.sv */
module eds_queue #(
    parameter int DEPTH = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr,
    input  eds_pkg::item_t wr_data,
    input  logic           rd,
    output eds_pkg::item_t rd_data,
    output logic           full,
    output logic           empty
);
    import eds_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST   = PTR_W'(DEPTH - 1);
    localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(DEPTH);

    item_t            mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0] level_reg, level_next;
    logic             do_wr, do_rd;

    assign full    = (level_reg == LVL_MAX);
    assign empty   = (level_reg == '0);
    assign do_wr   = wr && !full;
    assign do_rd   = rd && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* hdl/eds_back.sv */
module eds_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_empty,
    input  eds_pkg::item_t                     q_data,
    output logic                               q_rd,
    input  logic [eds_pkg::CNT_W-1:0]          counts_per_rev,
    input  logic                               pop,
    output logic                               empty,
    output logic signed [eds_pkg::DELTA_W-1:0] delta_counts,
    output logic signed [eds_pkg::SPEED_W-1:0] speed_rpm_q8,
    output logic                               baseline_only
);
    import eds_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;
    localparam int         STEP_W = $clog2(NUM_W + 1);

    logic [1:0]                state_reg, state_next;
    logic signed [DELTA_W-1:0] delta_reg, delta_next;
    logic [CNT_W-1:0]          dt_reg, dt_next;
    logic                      base_reg, base_next;
    logic                      zero_reg, zero_next;
    logic [NUM_W-1:0]          num_reg, num_next;
    logic [DEN_W-1:0]          den_reg, den_next;
    logic [DEN_W-1:0]          rem_reg, rem_next;
    logic [NUM_W-1:0]          quo_reg, quo_next;
    logic [STEP_W-1:0]         step_reg, step_next;

    logic                      out_valid_reg, out_valid_next;
    logic signed [DELTA_W-1:0] out_delta_reg;
    logic signed [SPEED_W-1:0] out_speed_reg;
    logic                      out_base_reg;

    logic [DELTA_W-1:0]        mag;
    logic [DEN_W:0]            rem_sh;
    logic [DEN_W:0]            rem_diff;
    logic                      ge;
    logic signed [SPEED_W-1:0] speed;
    logic                      load_out;
    logic                      neg;

    assign empty         = !out_valid_reg;
    assign delta_counts  = out_delta_reg;
    assign speed_rpm_q8  = out_speed_reg;
    assign baseline_only = out_base_reg;
    assign neg           = delta_reg[DELTA_W-1];

    always_comb
    begin
        mag      = neg ? DELTA_W'(-delta_reg) : DELTA_W'(delta_reg);
        rem_sh   = {rem_reg, num_reg[NUM_W-1]};
        rem_diff = rem_sh - {1'b0, den_reg};
        ge       = (rem_sh >= {1'b0, den_reg});

        // quotient is a magnitude; saturate on the 47-bit boundary for either sign
        if (zero_reg)
        begin
            speed = '0;
        end
        else if (quo_reg[NUM_W-1:SPEED_W-1] != '0)
        begin
            speed = neg ? SPEED_MIN : SPEED_MAX;
        end
        else if (neg)
        begin
            speed = -$signed({1'b0, quo_reg[SPEED_W-2:0]});
        end
        else
        begin
            speed = $signed({1'b0, quo_reg[SPEED_W-2:0]});
        end

        state_next     = state_reg;
        delta_next     = delta_reg;
        dt_next        = dt_reg;
        base_next      = base_reg;
        zero_next      = zero_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        step_next      = step_reg;
        q_rd           = 1'b0;
        load_out       = 1'b0;
        out_valid_next = out_valid_reg && !pop;

        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_rd       = 1'b1;
                    delta_next = q_data.delta;
                    dt_next    = q_data.dt;
                    base_next  = q_data.baseline;
                    zero_next  = q_data.baseline || (counts_per_rev == '0) ||
                                 (q_data.dt == '0);
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                num_next   = NUM_W'(mag) * NUM_W'(MS_PER_MIN_Q8);
                den_next   = DEN_W'(counts_per_rev) * DEN_W'(dt_reg);
                rem_next   = '0;
                quo_next   = '0;
                step_next  = STEP_W'(NUM_W);
                state_next = zero_reg ? S_DONE : S_DIV;
            end
            S_DIV:
            begin
                rem_next  = ge ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
                quo_next  = {quo_reg[NUM_W-2:0], ge};
                num_next  = {num_reg[NUM_W-2:0], 1'b0};
                step_next = step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || pop)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        delta_reg <= delta_next;
        dt_reg    <= dt_next;
        base_reg  <= base_next;
        zero_reg  <= zero_next;
        num_reg   <= num_next;
        den_reg   <= den_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        if (load_out)
        begin
            out_delta_reg <= delta_reg;
            out_speed_reg <= speed;
            out_base_reg  <= base_reg;
        end
    end

endmodule

/* hdl/encoder_delta_speed_core.sv */
// Encoder speed from count delta.
// Input queue side: drive counter_value and tick_ms with push; an item is taken
// on a clock edge with push high and full low. Result side: while empty is low,
// delta_counts, speed_rpm_q8 and baseline_only show the oldest result; pop with
// empty low takes it.
// Configuration: cfg_valid with cfg_index/cfg_data writes autoreload (0),
// counts_per_rev (1) or fallback_ms (2); other indexes are ignored. cfg_ready is
// always high. Write only while no item is in flight.
// Flow: an accepted item waits in the queue, then passes the back end's IDLE,
// MUL, DIV and DONE states before empty falls; DIV is skipped when the speed is
// forced to zero (baseline item or zero divisor). The 57-step restoring divider
// works on one item at a time; the front end fills a QUEUE_DEPTH-entry queue.
// A stalled result holds its value; the divider finishes the next item and
// waits, and full rises once the queue fills.
// Reset: registers return to defaults (65535, 1024, 10), the queue and result
// register empty, and the first item afterwards only captures the baseline.
module encoder_delta_speed_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic [eds_pkg::CNT_W-1:0]            counter_value,
    input  logic [eds_pkg::CNT_W-1:0]            tick_ms,
    output logic                                 empty,
    input  logic                                 pop,
    output logic signed [eds_pkg::DELTA_W-1:0]   delta_counts,
    output logic signed [eds_pkg::SPEED_W-1:0]   speed_rpm_q8,
    output logic                                 baseline_only,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [eds_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [eds_pkg::CNT_W-1:0]            cfg_data
);
    import eds_pkg::*;

    logic [CNT_W-1:0] autoreload_reg;
    logic [CNT_W-1:0] cpr_reg;
    logic [FB_W-1:0]  fallback_reg;

    logic  q_wr, q_rd, q_full, q_empty;
    item_t q_wr_data, q_rd_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            autoreload_reg <= AUTORELOAD_RST;
            cpr_reg        <= COUNTS_PER_REV_RST;
            fallback_reg   <= FALLBACK_MS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_AUTORELOAD:     autoreload_reg <= cfg_data;
                CFG_COUNTS_PER_REV: cpr_reg        <= cfg_data;
                CFG_FALLBACK_MS:    fallback_reg   <= cfg_data[FB_W-1:0];
                default:            ;
            endcase
        end
    end

    eds_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .counter_value (counter_value),
        .tick_ms       (tick_ms),
        .autoreload    (autoreload_reg),
        .fallback_ms   (fallback_reg),
        .q_full        (q_full),
        .q_wr          (q_wr),
        .q_data        (q_wr_data)
    );

    eds_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wr_data (q_wr_data),
        .rd      (q_rd),
        .rd_data (q_rd_data),
        .full    (q_full),
        .empty   (q_empty)
    );

    eds_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .q_data         (q_rd_data),
        .q_rd           (q_rd),
        .counts_per_rev (cpr_reg),
        .pop            (pop),
        .empty          (empty),
        .delta_counts   (delta_counts),
        .speed_rpm_q8   (speed_rpm_q8),
        .baseline_only  (baseline_only)
    );

endmodule

/* hdl/eds_checker.sv */
`include "encoder_delta_speed_core_macros.svh"

module eds_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               empty,
    input logic                               pop,
    input logic signed [eds_pkg::DELTA_W-1:0] delta_counts,
    input logic signed [eds_pkg::SPEED_W-1:0] speed_rpm_q8,
    input logic                               baseline_only
);
    import eds_pkg::*;

    `EDS_ASSERT_NOW(a_baseline_zero, !empty && baseline_only, (delta_counts == '0) && (speed_rpm_q8 == '0), "baseline result not zero")

    `EDS_ASSERT_NOW(a_still_zero, !empty && (delta_counts == '0), speed_rpm_q8 == '0, "speed nonzero with zero delta")

    `EDS_ASSERT_NOW(a_sign, !empty && (speed_rpm_q8 != '0), speed_rpm_q8[SPEED_W-1] == delta_counts[DELTA_W-1], "speed sign differs from delta sign")

    `EDS_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(delta_counts) && $stable(speed_rpm_q8) && $stable(baseline_only), "stalled result changed")

endmodule

bind encoder_delta_speed_core eds_checker u_eds_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .empty         (empty),
    .pop           (pop),
    .delta_counts  (delta_counts),
    .speed_rpm_q8  (speed_rpm_q8),
    .baseline_only (baseline_only)
);
